// ===== design/cpd_pkg.sv =====
// Shared types, widths and codes of the CAN PDO receive demultiplexer.
package cpd_pkg;

    localparam int NODE_SLOTS_DEF = 16;

    localparam int ID_W      = 11;
    localparam int RAW_ID_W  = 32;
    localparam int DLC_W     = 4;
    localparam int DATA_W    = 64;
    localparam int FILL_W    = 5;
    localparam int KIND_W    = 2;
    localparam int SLOT_OUT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam int FRAME_BYTES = 8;

    localparam logic [ID_W-1:0] TPDO_FIRST_RST  = ID_W'(384);
    localparam logic [ID_W-1:0] TPDO_SECOND_RST = ID_W'(640);
    localparam logic [ID_W-1:0] HEARTBEAT_RST   = ID_W'(1792);

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_IGNORED     = 2'd0;
    localparam t_kind KIND_TPDO_FIRST  = 2'd1;
    localparam t_kind KIND_TPDO_SECOND = 2'd2;
    localparam t_kind KIND_HEARTBEAT   = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_TPDO_FIRST  = 2'd0;
    localparam t_cfg_idx REG_TPDO_SECOND = 2'd1;
    localparam t_cfg_idx REG_HEARTBEAT   = 2'd2;

    // One node's record in the node memory.
    typedef struct packed {
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        logic [FILL_W-1:0] fill;
        logic              updated;
        logic              present;
    } t_entry;

endpackage

// ===== design/cpd_intf.sv =====
// Handshake channel interfaces for frames, results and configuration writes.
interface cpd_frame_if;
    logic                          valid;
    logic                          ready;
    logic [cpd_pkg::RAW_ID_W-1:0]  raw_ident;
    logic [cpd_pkg::DLC_W-1:0]     byte_count;
    logic [cpd_pkg::DATA_W-1:0]    payload;

    modport source (output valid, raw_ident, byte_count, payload, input ready);
    modport sink   (input valid, raw_ident, byte_count, payload, output ready);
endinterface

interface cpd_result_if;
    logic                           valid;
    logic                           ready;
    logic [cpd_pkg::KIND_W-1:0]     frame_kind;
    logic [cpd_pkg::SLOT_OUT_W-1:0] slot;
    logic [cpd_pkg::DATA_W-1:0]     buffer_lower;
    logic [cpd_pkg::DATA_W-1:0]     buffer_upper;
    logic [cpd_pkg::FILL_W-1:0]     filled_bytes;
    logic                           fresh_mark;
    logic                           seen_mark;

    modport source (output valid, frame_kind, slot, buffer_lower, buffer_upper,
                    filled_bytes, fresh_mark, seen_mark, input ready);
    modport sink   (input valid, frame_kind, slot, buffer_lower, buffer_upper,
                    filled_bytes, fresh_mark, seen_mark, output ready);
endinterface

interface cpd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cpd_pkg::CFG_IDX_W-1:0] reg_index;
    logic [cpd_pkg::ID_W-1:0]      wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== design/can_pdo_receive_demux.sv =====
// Top level of the CAN PDO receive demultiplexer with its node memory.
//
// The block takes one received CAN frame per item, masks the identifier to
// 11 bits and classifies it as first TPDO, second TPDO or heartbeat against
// three base identifiers, each followed by a window of NODE_SLOTS node
// numbers (checked in that order; node 0 is ignored). Per node it keeps a
// 16-byte buffer, a fill count and updated and present marks in one node
// memory with registered read data. A frame is taken in the idle state,
// which classifies it and reads the node's record; the merge state then
// merges the data bytes, writes the record back and loads the result
// register. A new frame is accepted only after that merge is done, and
// the result register holds a finished result while the next frame is
// taken in; the merge state waits only when that register is still full.
// After reset all node records read as zero at once, through one valid bit
// per node, so no clearing pass is needed. Configuration writes are always
// accepted and take effect from the next frame on; index values beyond the
// three base registers are accepted and dropped.
module can_pdo_receive_demux #(
    parameter int NODE_SLOTS = cpd_pkg::NODE_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cpd_frame_if.sink            i_frame,
    cpd_cfg_if.sink              i_cfg,
    cpd_result_if.source         o_result
);

    localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    // Base identifier registers.
    logic [cpd_pkg::ID_W-1:0] r_base_first;
    logic [cpd_pkg::ID_W-1:0] r_base_second;
    logic [cpd_pkg::ID_W-1:0] r_base_hb;

    // Sequencer and captured frame.
    logic                         r_state;
    cpd_pkg::t_kind               r_kind;
    logic [SLOT_W-1:0]            r_node;
    logic [cpd_pkg::DLC_W-1:0]    r_dlc;
    logic [cpd_pkg::DATA_W-1:0]   r_data;

    // Node memory, its per-node valid bits and the registered read port.
    cpd_pkg::t_entry              r_mem [NODE_SLOTS];
    logic [NODE_SLOTS-1:0]        r_valid;
    cpd_pkg::t_entry              r_rd_entry;
    logic                         r_rd_vld;

    // Result register.
    logic                           r_out_valid;
    cpd_pkg::t_kind                 r_out_kind;
    logic [cpd_pkg::SLOT_OUT_W-1:0] r_out_slot;
    cpd_pkg::t_entry                r_out_entry;

    logic                         w_accept;
    logic                         w_out_take;
    logic                         w_load;
    logic                         w_wr_en;
    cpd_pkg::t_kind               w_kind;
    logic [SLOT_W-1:0]            w_node;
    logic [cpd_pkg::DLC_W-1:0]    w_dlc;
    cpd_pkg::t_entry              w_old;
    cpd_pkg::t_entry              n_entry;
    logic [cpd_pkg::DATA_W-1:0]   w_mask;
    logic [cpd_pkg::FILL_W-1:0]   w_end;

    assign i_frame.ready = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign w_accept      = i_frame.valid && i_frame.ready;
    assign w_out_take    = r_out_valid && o_result.ready;
    assign w_load        = (r_state == ST_MERGE) && (!r_out_valid || o_result.ready);
    assign w_wr_en       = w_load && (r_kind != cpd_pkg::KIND_IGNORED);

    // Window checks on the masked identifier, in priority order.
    always_comb begin
        logic [cpd_pkg::ID_W-1:0] id;
        logic [cpd_pkg::ID_W-1:0] d_first;
        logic [cpd_pkg::ID_W-1:0] d_second;
        logic [cpd_pkg::ID_W-1:0] d_hb;
        logic                     h_first;
        logic                     h_second;
        logic                     h_hb;
        logic [cpd_pkg::ID_W-1:0] diff;
        id       = i_frame.raw_ident[cpd_pkg::ID_W-1:0];
        d_first  = id - r_base_first;
        d_second = id - r_base_second;
        d_hb     = id - r_base_hb;
        h_first  = (id >= r_base_first)  && (d_first  < cpd_pkg::ID_W'(NODE_SLOTS));
        h_second = (id >= r_base_second) && (d_second < cpd_pkg::ID_W'(NODE_SLOTS));
        h_hb     = (id >= r_base_hb)     && (d_hb     < cpd_pkg::ID_W'(NODE_SLOTS));
        w_kind = cpd_pkg::KIND_IGNORED;
        diff   = '0;
        priority if (h_first) begin
            w_kind = cpd_pkg::KIND_TPDO_FIRST;
            diff   = d_first;
        end else if (h_second) begin
            w_kind = cpd_pkg::KIND_TPDO_SECOND;
            diff   = d_second;
        end else if (h_hb) begin
            w_kind = cpd_pkg::KIND_HEARTBEAT;
            diff   = d_hb;
        end else begin
            w_kind = cpd_pkg::KIND_IGNORED;
            diff   = '0;
        end
        w_node = diff[SLOT_W-1:0];
        if (w_node == '0) begin
            w_kind = cpd_pkg::KIND_IGNORED;
        end
        if (i_frame.byte_count > cpd_pkg::DLC_W'(cpd_pkg::FRAME_BYTES)) begin
            w_dlc = cpd_pkg::DLC_W'(cpd_pkg::FRAME_BYTES);
        end else begin
            w_dlc = i_frame.byte_count;
        end
    end

    // Merge of the frame into the node's record.
    always_comb begin
        logic [cpd_pkg::FILL_W-1:0] offset;
        w_old = r_rd_vld ? r_rd_entry : '0;
        for (int k = 0; k < cpd_pkg::FRAME_BYTES; k++) begin
            w_mask[8*k +: 8] = (cpd_pkg::DLC_W'(k) < r_dlc) ? 8'hFF : 8'h00;
        end
        offset  = (r_kind == cpd_pkg::KIND_TPDO_SECOND)
                  ? cpd_pkg::FILL_W'(cpd_pkg::FRAME_BYTES) : '0;
        w_end   = offset + cpd_pkg::FILL_W'(r_dlc);
        n_entry = w_old;
        n_entry.present = 1'b1;
        unique case (r_kind)
            cpd_pkg::KIND_TPDO_FIRST: begin
                n_entry.lower   = (w_old.lower & ~w_mask) | (r_data & w_mask);
                n_entry.updated = 1'b1;
                if (w_end > w_old.fill) begin
                    n_entry.fill = w_end;
                end
            end
            cpd_pkg::KIND_TPDO_SECOND: begin
                n_entry.upper   = (w_old.upper & ~w_mask) | (r_data & w_mask);
                n_entry.updated = 1'b1;
                if (w_end > w_old.fill) begin
                    n_entry.fill = w_end;
                end
            end
            cpd_pkg::KIND_HEARTBEAT: begin
            end
            default: begin
                n_entry = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_first  <= cpd_pkg::TPDO_FIRST_RST;
            r_base_second <= cpd_pkg::TPDO_SECOND_RST;
            r_base_hb     <= cpd_pkg::HEARTBEAT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                cpd_pkg::REG_TPDO_FIRST:  r_base_first  <= i_cfg.wr_data;
                cpd_pkg::REG_TPDO_SECOND: r_base_second <= i_cfg.wr_data;
                cpd_pkg::REG_HEARTBEAT:   r_base_hb     <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, result valid and per-node valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_valid[r_node] <= 1'b1;
            end
        end
    end

    // Captured frame and node memory ports.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind     <= w_kind;
            r_node     <= (w_kind == cpd_pkg::KIND_IGNORED) ? '0 : w_node;
            r_dlc      <= w_dlc;
            r_data     <= i_frame.payload;
            r_rd_entry <= r_mem[w_node];
            r_rd_vld   <= r_valid[w_node];
        end
        if (w_wr_en) begin
            r_mem[r_node] <= n_entry;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind  <= r_kind;
            r_out_slot  <= cpd_pkg::SLOT_OUT_W'(r_node);
            r_out_entry <= n_entry;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.frame_kind   = r_out_kind;
    assign o_result.slot         = r_out_slot;
    assign o_result.buffer_lower = r_out_entry.lower;
    assign o_result.buffer_upper = r_out_entry.upper;
    assign o_result.filled_bytes = r_out_entry.fill;
    assign o_result.fresh_mark   = r_out_entry.updated;
    assign o_result.seen_mark    = r_out_entry.present;

`ifndef SYNTHESIS
    // An accepted frame always moves the sequencer into the merge cycle.
    a_accept_to_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MERGE))
        else $error("accepted frame did not enter merge cycle");

    // The node memory is written only while a merge completes.
    a_write_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == ST_MERGE) && (r_kind != cpd_pkg::KIND_IGNORED))
        else $error("node memory written outside a merge");

    // An ignored frame reports node zero and an empty record.
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == cpd_pkg::KIND_IGNORED) |->
            (r_out_slot == '0) && (r_out_entry == '0))
        else $error("ignored frame result not all zero");

    // A TPDO result always carries both marks of its node.
    a_tpdo_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == cpd_pkg::KIND_TPDO_FIRST ||
                         r_out_kind == cpd_pkg::KIND_TPDO_SECOND)) |->
            (r_out_entry.updated && r_out_entry.present))
        else $error("TPDO result without updated and present marks");

    // A result waiting in the register is not overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> $stable(r_out_entry))
        else $error("pending result overwritten");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the CAN PDO receive demultiplexer.
`timescale 1ns / 1ps

module testbench;

    localparam int NODE_SLOTS = cpd_pkg::NODE_SLOTS_DEF;

    // Random items per configuration phase, and the number of phases.
    localparam int PHASE_ITEMS = 275;
    localparam int PHASES      = 6;

    // Length of the one long receiver hold, in cycles.
    localparam int LONG_HOLD = 300;

    // A new item waits until the last one is through the merge, so a few idle
    // cycles are enough to be sure that nothing is still in flight.
    localparam int SETTLE_CYCLES = 4;

    // The spare register index is accepted by the block and dropped.
    localparam cpd_pkg::t_cfg_idx REG_SPARE = 2'd3;

    // The node view that one frame produces.
    typedef struct packed {
        cpd_pkg::t_kind                 kind;
        logic [cpd_pkg::SLOT_OUT_W-1:0] slot;
        logic [cpd_pkg::DATA_W-1:0]     lower;
        logic [cpd_pkg::DATA_W-1:0]     upper;
        logic [cpd_pkg::FILL_W-1:0]     fill;
        logic                           fresh;
        logic                           seen;
    } t_node_view;

    localparam t_node_view IGNORED_VIEW = '0;

    // One row of the directed table. When typed is low the view is unused
    // and the row is checked against the predictor instead.
    typedef struct packed {
        logic [cpd_pkg::RAW_ID_W-1:0] raw;
        logic [cpd_pkg::DLC_W-1:0]    dlc;
        logic [cpd_pkg::DATA_W-1:0]   data;
        logic                         typed;
        t_node_view                   want;
    } t_frame_row;

    localparam logic TYPED        = 1'b1;
    localparam logic BY_PREDICTOR = 1'b0;
    localparam int   DIRECTED_ROWS = 15;

    // The directed rows run with the base identifiers at their reset values:
    // first TPDO at 384, second TPDO at 640 and heartbeat at 1792.
    t_frame_row directed_rows [DIRECTED_ROWS] = '{
        // Node 0 of the first TPDO window is ignored.
        {32'h0000_0180, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, IGNORED_VIEW},
        // All identifier bits set: id 2047 lies outside every window.
        {32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, IGNORED_VIEW},
        // Full first TPDO to node 1.
        {32'h0000_0181, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, TYPED,
         {cpd_pkg::KIND_TPDO_FIRST, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
          5'd8, 1'b1, 1'b1}},
        // Second TPDO to node 1 with a long length code, filling all 16 bytes.
        {32'h0000_0281, 4'd15, 64'h0123_4567_89AB_CDEF, TYPED,
         {cpd_pkg::KIND_TPDO_SECOND, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF,
          64'h0123_4567_89AB_CDEF, 5'd16, 1'b1, 1'b1}},
        // Heartbeat from the top node of the window marks it seen only.
        {32'h0000_070F, 4'd0, 64'd0, TYPED,
         {cpd_pkg::KIND_HEARTBEAT, 7'd15, 64'd0, 64'd0, 5'd0, 1'b0, 1'b1}},
        // Empty first TPDO: no data bytes, the fill stays at its offset of 0.
        {32'h0000_018F, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, TYPED,
         {cpd_pkg::KIND_TPDO_FIRST, 7'd15, 64'd0, 64'd0, 5'd0, 1'b1, 1'b1}},
        // Empty second TPDO: the fill is raised to its offset of 8.
        {32'h0000_028E, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, TYPED,
         {cpd_pkg::KIND_TPDO_SECOND, 7'd14, 64'd0, 64'd0, 5'd8, 1'b1, 1'b1}},
        // One past the first TPDO window, and one below it.
        {32'h0000_0190, 4'd8, 64'h1111_2222_3333_4444, TYPED, IGNORED_VIEW},
        {32'h0000_017F, 4'd8, 64'h1111_2222_3333_4444, TYPED, IGNORED_VIEW},
        // Partial merges into node 2, with junk in the upper identifier bits.
        {32'h8000_0182, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, BY_PREDICTOR, IGNORED_VIEW},
        {32'h7FFF_F982, 4'd1, 64'h5555_5555_5555_5555, BY_PREDICTOR, IGNORED_VIEW},
        {32'h0000_0282, 4'd5, 64'hDEAD_BEEF_0BAD_F00D, BY_PREDICTOR, IGNORED_VIEW},
        {32'h0000_0702, 4'd9, 64'h0F0F_0F0F_0F0F_0F0F, BY_PREDICTOR, IGNORED_VIEW},
        // Heartbeat to node 0 is ignored.
        {32'h0000_0700, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, IGNORED_VIEW},
        // Short overwrite of node 1's first two bytes.
        {32'h0000_0181, 4'd2, 64'h0000_0000_0000_0000, BY_PREDICTOR, IGNORED_VIEW}
    };

    logic i_clk;
    logic i_rst_n;

    cpd_frame_if  frame_ch ();
    cpd_cfg_if    cfg_ch ();
    cpd_result_if result_ch ();

    can_pdo_receive_demux #(
        .NODE_SLOTS(NODE_SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_ch),
        .i_cfg   (cfg_ch),
        .o_result(result_ch)
    );

    // Predictor copy of the base registers and of the per-node records.
    logic [cpd_pkg::ID_W-1:0]   first_base  = cpd_pkg::TPDO_FIRST_RST;
    logic [cpd_pkg::ID_W-1:0]   second_base = cpd_pkg::TPDO_SECOND_RST;
    logic [cpd_pkg::ID_W-1:0]   beat_base   = cpd_pkg::HEARTBEAT_RST;
    logic [cpd_pkg::DATA_W-1:0] node_lower   [NODE_SLOTS] = '{default: '0};
    logic [cpd_pkg::DATA_W-1:0] node_upper   [NODE_SLOTS] = '{default: '0};
    logic [cpd_pkg::FILL_W-1:0] node_fill    [NODE_SLOTS] = '{default: '0};
    logic                       node_updated [NODE_SLOTS] = '{default: 1'b0};
    logic                       node_present [NODE_SLOTS] = '{default: 1'b0};

    // Node views still owed by the block, oldest first.
    t_node_view awaited_views [$];

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  hold_requests = 0;
    bit  steady        = 1'b0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Idle gap length: mostly none, some short, a few long. During a steady
    // stretch neither side idles at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (steady || roll < 12)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Gives the node number when id falls within the window that starts at base.
    function automatic bit node_in_window(logic [cpd_pkg::ID_W-1:0] id,
                                          logic [cpd_pkg::ID_W-1:0] base,
                                          output int node);
        int offset;
        offset = int'(id) - int'(base);
        node   = offset;
        return offset >= 0 && offset < NODE_SLOTS;
    endfunction

    // Classifies one frame, merges it into the predicted node record and
    // returns the view of that node that the block has to report.
    function automatic t_node_view classify_and_merge(
        logic [cpd_pkg::RAW_ID_W-1:0] raw,
        logic [cpd_pkg::DLC_W-1:0]    dlc,
        logic [cpd_pkg::DATA_W-1:0]   data);
        logic [cpd_pkg::ID_W-1:0]   id;
        logic [cpd_pkg::DATA_W-1:0] keep;
        int                         len;
        int                         node;
        int                         span_end;
        cpd_pkg::t_kind             kind;
        t_node_view                 view;

        id   = raw[cpd_pkg::ID_W-1:0];
        len  = (dlc > cpd_pkg::DLC_W'(cpd_pkg::FRAME_BYTES)) ? cpd_pkg::FRAME_BYTES
                                                             : int'(dlc);
        kind = cpd_pkg::KIND_IGNORED;
        node = 0;

        // The windows are tried in a fixed order; the first hit wins when
        // the windows overlap.
        if (node_in_window(id, first_base, node))
            kind = cpd_pkg::KIND_TPDO_FIRST;
        else if (node_in_window(id, second_base, node))
            kind = cpd_pkg::KIND_TPDO_SECOND;
        else if (node_in_window(id, beat_base, node))
            kind = cpd_pkg::KIND_HEARTBEAT;
        else
            node = 0;

        if (node == 0)
            kind = cpd_pkg::KIND_IGNORED;
        if (kind == cpd_pkg::KIND_IGNORED)
            return IGNORED_VIEW;

        if (kind != cpd_pkg::KIND_HEARTBEAT) begin
            keep = (len == cpd_pkg::FRAME_BYTES) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            if (kind == cpd_pkg::KIND_TPDO_FIRST) begin
                node_lower[node] = (node_lower[node] & ~keep) | (data & keep);
                span_end = len;
            end else begin
                node_upper[node] = (node_upper[node] & ~keep) | (data & keep);
                span_end = cpd_pkg::FRAME_BYTES + len;
            end
            if (span_end > int'(node_fill[node]))
                node_fill[node] = cpd_pkg::FILL_W'(span_end);
            node_updated[node] = 1'b1;
        end
        node_present[node] = 1'b1;

        view.kind  = kind;
        view.slot  = cpd_pkg::SLOT_OUT_W'(node);
        view.lower = node_lower[node];
        view.upper = node_upper[node];
        view.fill  = node_fill[node];
        view.fresh = node_updated[node];
        view.seen  = node_present[node];
        return view;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s in result %0d: got %h, wanted %h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    // Offers one frame and holds it until it is taken. The expected view is
    // worked out at the edge that accepts it, so the predictor sees frames in
    // the same order as the block. A typed row overrides the predicted view,
    // but the predictor still runs to keep its records in step.
    task automatic offer_frame(logic [cpd_pkg::RAW_ID_W-1:0] raw,
                               logic [cpd_pkg::DLC_W-1:0] dlc,
                               logic [cpd_pkg::DATA_W-1:0] data, logic typed,
                               t_node_view want);
        t_node_view predicted;
        int         gap;

        frame_ch.valid      <= 1'b1;
        frame_ch.raw_ident  <= raw;
        frame_ch.byte_count <= dlc;
        frame_ch.payload    <= data;
        do @(posedge i_clk); while (frame_ch.ready !== 1'b1);

        predicted = classify_and_merge(raw, dlc, data);
        awaited_views.push_back(typed ? want : predicted);

        // With no gap the valid stays high for the next frame, so it is not
        // touched again in this time step.
        gap = pick_gap();
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering frames and waits until every owed view has come back.
    task automatic drain_block();
        frame_ch.valid <= 1'b0;
        while (awaited_views.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the three base registers, and the spare index when asked. The
    // block must be idle when this is called.
    task automatic program_bases(logic [cpd_pkg::ID_W-1:0] first,
                                 logic [cpd_pkg::ID_W-1:0] second,
                                 logic [cpd_pkg::ID_W-1:0] beat, bit with_spare);
        cpd_pkg::t_cfg_idx        order  [4];
        logic [cpd_pkg::ID_W-1:0] values [4];
        int                       count;

        order  = '{REG_SPARE, cpd_pkg::REG_TPDO_FIRST, cpd_pkg::REG_TPDO_SECOND,
                   cpd_pkg::REG_HEARTBEAT};
        values = '{cpd_pkg::ID_W'($urandom), first, second, beat};
        count  = 4;
        for (int i = with_spare ? 0 : 1; i < count; i++) begin
            cfg_ch.valid     <= 1'b1;
            cfg_ch.reg_index <= order[i];
            cfg_ch.wr_data   <= values[i];
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
            case (order[i])
                cpd_pkg::REG_TPDO_FIRST:  first_base  = values[i];
                cpd_pkg::REG_TPDO_SECOND: second_base = values[i];
                cpd_pkg::REG_HEARTBEAT:   beat_base   = values[i];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: checks every accepted view against the oldest one owed and
    // drives ready with random stalls. A long hold is requested from the
    // stimulus process and counted out here.
    initial begin : result_side
        int         stall_left;
        int         holds_served;
        t_node_view want;

        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                if (awaited_views.size() == 0) begin
                    note_mismatch("unexpected result", {62'd0, result_ch.frame_kind}, 64'd0);
                end else begin
                    want = awaited_views.pop_front();
                    if (result_ch.frame_kind !== want.kind)
                        note_mismatch("frame_kind", 64'(result_ch.frame_kind), 64'(want.kind));
                    if (result_ch.slot !== want.slot)
                        note_mismatch("slot", 64'(result_ch.slot), 64'(want.slot));
                    if (result_ch.buffer_lower !== want.lower)
                        note_mismatch("buffer_lower", result_ch.buffer_lower, want.lower);
                    if (result_ch.buffer_upper !== want.upper)
                        note_mismatch("buffer_upper", result_ch.buffer_upper, want.upper);
                    if (result_ch.filled_bytes !== want.fill)
                        note_mismatch("filled_bytes", 64'(result_ch.filled_bytes),
                                      64'(want.fill));
                    if (result_ch.fresh_mark !== want.fresh)
                        note_mismatch("fresh_mark", 64'(result_ch.fresh_mark), 64'(want.fresh));
                    if (result_ch.seen_mark !== want.seen)
                        note_mismatch("seen_mark", 64'(result_ch.seen_mark), 64'(want.seen));
                end
                results_seen++;
            end

            if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus: reset, the directed table, then random frames over several
    // settings of the base registers.
    initial begin : frame_side
        logic [cpd_pkg::ID_W-1:0]     base;
        logic [cpd_pkg::ID_W-1:0]     id;
        logic [cpd_pkg::RAW_ID_W-1:0] raw;
        int                           node;

        i_rst_n             = 1'b0;
        frame_ch.valid      = 1'b0;
        frame_ch.raw_ident  = '0;
        frame_ch.byte_count = '0;
        frame_ch.payload    = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.reg_index    = cpd_pkg::REG_TPDO_FIRST;
        cfg_ch.wr_data      = '0;
        result_ch.ready     = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: extremes of the fields, every frame kind, and the
        // ignored, empty and long-length cases.
        foreach (directed_rows[r])
            offer_frame(directed_rows[r].raw, directed_rows[r].dlc, directed_rows[r].data,
                        directed_rows[r].typed, directed_rows[r].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            // Phase 0 keeps the reset bases. Later phases go through all-zero
            // bases (every window overlaps, first TPDO wins), the two ends of
            // the range with a window running past id 2047, a tightly
            // interleaved set, and random sets.
            if (phase > 0) begin
                drain_block();
                case (phase)
                    1:       program_bases(11'd0, 11'd0, 11'd0, 1'b0);
                    2:       program_bases(11'd2047, 11'd2040, 11'd0, 1'b1);
                    3:       program_bases(11'd100, 11'd108, 11'd104, 1'b0);
                    default: program_bases(cpd_pkg::ID_W'($urandom),
                                           cpd_pkg::ID_W'($urandom),
                                           cpd_pkg::ID_W'($urandom),
                                           phase == PHASES - 1);
                endcase
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady = (n >= 180 && n < 230);

                // In one phase the receiver stops for a long stretch while
                // frames keep coming, so the block backs up into its input.
                if (phase == 3 && n == 60)
                    hold_requests++;
                // In another the sender waits until the block is empty.
                if (phase == 4 && n == 120)
                    drain_block();

                // Most frames aim at a window, mostly at a live node and now
                // and then at node 0 or just past the window; the rest carry
                // a fully random identifier.
                raw = $urandom;
                if ($urandom_range(0, 9) != 0) begin
                    case ($urandom_range(0, 2))
                        0:       base = first_base;
                        1:       base = second_base;
                        default: base = beat_base;
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        node = $urandom_range(0, 1) ? NODE_SLOTS : 0;
                    else
                        node = $urandom_range(1, NODE_SLOTS - 1);
                    id = base + cpd_pkg::ID_W'(node);
                    raw[cpd_pkg::ID_W-1:0] = id;
                end
                offer_frame(raw, cpd_pkg::DLC_W'($urandom_range(0, 15)),
                            {$urandom, $urandom}, BY_PREDICTOR, IGNORED_VIEW);
            end
        end
        steady = 1'b0;

        drain_block();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && awaited_views.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cpd_pkg.sv
design/cpd_intf.sv
design/can_pdo_receive_demux.sv
dv/testbench.sv
